@@ rtl/tpqs_pkg.sv @@
`default_nettype none

package tpqs_pkg;

    localparam int unsigned CNT_W       = 32;
    localparam int unsigned TOT_W       = 48;
    localparam int unsigned TAG_W       = 16;
    localparam int unsigned TIME_W      = 32;
    localparam int unsigned OP_W        = 2;
    localparam int unsigned STATUS_W    = 3;
    localparam int unsigned LIMIT_W     = 5;
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 5'd16;

    // upper op bit selects a tick, lower bit selects the class of a request
    localparam int unsigned OP_TICK_BIT  = 1;
    localparam int unsigned OP_CLASS_BIT = 0;

    localparam logic [STATUS_W-1:0] STATUS_ACCEPTED   = 3'd0;
    localparam logic [STATUS_W-1:0] STATUS_REFUSED    = 3'd1;
    localparam logic [STATUS_W-1:0] STATUS_HIGH_SERVE = 3'd2;
    localparam logic [STATUS_W-1:0] STATUS_LOW_SERVE  = 3'd3;
    localparam logic [STATUS_W-1:0] STATUS_IDLE       = 3'd4;

    localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};
    localparam logic [TOT_W-1:0] TOT_MAX = {TOT_W{1'b1}};

    typedef struct packed {
        logic [TAG_W-1:0]  tag;
        logic [TIME_W-1:0] start;
    } entry_t;

    typedef struct packed {
        logic req_high;
        logic req_low;
        logic ref_high;
        logic ref_low;
        logic srv_high;
        logic srv_low;
        logic idle;
    } stat_evt_t;

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
        logic [CNT_W-1:0] r;
        r = (v == CNT_MAX) ? v : v + 1'b1;
        return r;
    endfunction

    function automatic logic [TOT_W-1:0] sat_add(input logic [TOT_W-1:0] total,
                                                 input logic [TIME_W-1:0] add);
        logic [TOT_W:0] s;
        s = {1'b0, total} + (TOT_W + 1)'(add);
        return s[TOT_W] ? TOT_MAX : s[TOT_W-1:0];
    endfunction

endpackage

`default_nettype wire

@@ rtl/tpqs_queue_mem.sv @@
`default_nettype none

module tpqs_queue_mem #(
    parameter int unsigned DEPTH = 16,
    parameter int unsigned PTR_W = 4
) (
    input  wire                  clk,
    input  wire                  we,
    input  wire [PTR_W-1:0]      waddr,
    input  wire tpqs_pkg::entry_t wdata,
    input  wire                  re,
    input  wire [PTR_W-1:0]      raddr,
    output tpqs_pkg::entry_t     rdata
);

    tpqs_pkg::entry_t mem [DEPTH];
    tpqs_pkg::entry_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

@@ rtl/tpqs_stats.sv @@
`default_nettype none

module tpqs_stats (
    input  wire                               clk,
    input  wire                               rst_n,
    input  wire tpqs_pkg::stat_evt_t          evt,
    input  wire [tpqs_pkg::TIME_W-1:0]        wait_val,
    output logic [tpqs_pkg::CNT_W-1:0]        high_requests,
    output logic [tpqs_pkg::CNT_W-1:0]        high_refused,
    output logic [tpqs_pkg::CNT_W-1:0]        low_requests,
    output logic [tpqs_pkg::CNT_W-1:0]        low_refused,
    output logic [tpqs_pkg::CNT_W-1:0]        high_served,
    output logic [tpqs_pkg::CNT_W-1:0]        low_served,
    output logic [tpqs_pkg::TOT_W-1:0]        high_wait_total,
    output logic [tpqs_pkg::TOT_W-1:0]        low_wait_total,
    output logic [tpqs_pkg::CNT_W-1:0]        idle_ticks
);

    logic [tpqs_pkg::CNT_W-1:0] high_req_reg, high_ref_reg, low_req_reg, low_ref_reg;
    logic [tpqs_pkg::CNT_W-1:0] high_srv_reg, low_srv_reg, idle_reg;
    logic [tpqs_pkg::TOT_W-1:0] high_tot_reg, low_tot_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            high_req_reg <= '0;
            high_ref_reg <= '0;
            low_req_reg  <= '0;
            low_ref_reg  <= '0;
            high_srv_reg <= '0;
            low_srv_reg  <= '0;
            idle_reg     <= '0;
            high_tot_reg <= '0;
            low_tot_reg  <= '0;
        end
        else
        begin
            if (evt.req_high) high_req_reg <= tpqs_pkg::sat_inc(high_req_reg);
            if (evt.ref_high) high_ref_reg <= tpqs_pkg::sat_inc(high_ref_reg);
            if (evt.req_low)  low_req_reg  <= tpqs_pkg::sat_inc(low_req_reg);
            if (evt.ref_low)  low_ref_reg  <= tpqs_pkg::sat_inc(low_ref_reg);
            if (evt.idle)     idle_reg     <= tpqs_pkg::sat_inc(idle_reg);
            if (evt.srv_high)
            begin
                high_srv_reg <= tpqs_pkg::sat_inc(high_srv_reg);
                high_tot_reg <= tpqs_pkg::sat_add(high_tot_reg, wait_val);
            end
            if (evt.srv_low)
            begin
                low_srv_reg <= tpqs_pkg::sat_inc(low_srv_reg);
                low_tot_reg <= tpqs_pkg::sat_add(low_tot_reg, wait_val);
            end
        end
    end

    assign high_requests   = high_req_reg;
    assign high_refused    = high_ref_reg;
    assign low_requests    = low_req_reg;
    assign low_refused     = low_ref_reg;
    assign high_served     = high_srv_reg;
    assign low_served      = low_srv_reg;
    assign high_wait_total = high_tot_reg;
    assign low_wait_total  = low_tot_reg;
    assign idle_ticks      = idle_reg;

endmodule

`default_nettype wire

@@ rtl/two_class_priority_queue_server.sv @@
// Two-class strict-priority queue server.
// Item channel: an item (op, plane_tag, start_time, current_time) is taken at a
// rising edge where start is high and busy is low. op 0/1 is a high/low request,
// op 2 or 3 is a service tick.
// Result channel: done is high for one cycle with status, served_tag, served_wait
// and all statistics counters; the receiver cannot stall, so results are never held.
// A request or an idle tick gives its result in the cycle after it is taken; a serving
// tick first reads the head entry from the class queue memory into the memory's read
// register, then registers the result. busy is high during that read.
// One request or idle tick per cycle while busy is low; no item is taken during a read.
// A new item may be taken in the same cycle that the previous result is shown.
// Config channel: cfg_data (entry limit per class) is written when cfg_valid and
// cfg_ready are high; cfg_ready is always high. Write it only while no item is in flight.
// Reset clears queue occupancy, heads, counters and totals and sets the limit to 16;
// queue memory contents are not cleared and need no clearing pass.
`default_nettype none

module two_class_priority_queue_server #(
    parameter int unsigned QUEUE_DEPTH = 16
) (
    input  wire                                clk,
    input  wire                                rst_n,
    input  wire                                start,
    output logic                               busy,
    input  wire [tpqs_pkg::OP_W-1:0]           op,
    input  wire [tpqs_pkg::TAG_W-1:0]          plane_tag,
    input  wire [tpqs_pkg::TIME_W-1:0]         start_time,
    input  wire [tpqs_pkg::TIME_W-1:0]         current_time,
    input  wire                                cfg_valid,
    output logic                               cfg_ready,
    input  wire [tpqs_pkg::LIMIT_W-1:0]        cfg_data,
    output logic                               done,
    output logic [tpqs_pkg::STATUS_W-1:0]      status,
    output logic [tpqs_pkg::TAG_W-1:0]         served_tag,
    output logic [tpqs_pkg::TIME_W-1:0]        served_wait,
    output logic [tpqs_pkg::CNT_W-1:0]         high_requests,
    output logic [tpqs_pkg::CNT_W-1:0]         high_refused,
    output logic [tpqs_pkg::CNT_W-1:0]         low_requests,
    output logic [tpqs_pkg::CNT_W-1:0]         low_refused,
    output logic [tpqs_pkg::CNT_W-1:0]         high_served,
    output logic [tpqs_pkg::CNT_W-1:0]         low_served,
    output logic [tpqs_pkg::TOT_W-1:0]         high_wait_total,
    output logic [tpqs_pkg::TOT_W-1:0]         low_wait_total,
    output logic [tpqs_pkg::CNT_W-1:0]         idle_ticks
);

    localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int unsigned OCC_W = $clog2(QUEUE_DEPTH + 1);
    localparam int unsigned CMP_W = (OCC_W > tpqs_pkg::LIMIT_W) ? OCC_W : tpqs_pkg::LIMIT_W;
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [PTR_W:0]   SUM_DEPTH = (PTR_W + 1)'(QUEUE_DEPTH);
    localparam logic [CMP_W-1:0] CMP_DEPTH = CMP_W'(QUEUE_DEPTH);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_READ = 2'b10
    } state_t;

    state_t state_reg, state_next;

    logic [tpqs_pkg::LIMIT_W-1:0] limit_reg;
    logic [PTR_W-1:0] hi_head_reg, hi_head_next, lo_head_reg, lo_head_next;
    logic [OCC_W-1:0] hi_occ_reg, hi_occ_next, lo_occ_reg, lo_occ_next;
    logic             srv_cls_reg, srv_cls_next;
    logic [tpqs_pkg::TIME_W-1:0] now_reg, now_next;
    logic             done_reg, done_next;
    logic [tpqs_pkg::STATUS_W-1:0] status_reg, status_next;
    logic [tpqs_pkg::TAG_W-1:0]    tag_reg, tag_next;
    logic [tpqs_pkg::TIME_W-1:0]   wait_reg, wait_next;

    logic             accept, is_tick, cls, room;
    logic [OCC_W-1:0] occ_sel;
    logic [PTR_W-1:0] head_sel, tail;
    logic [PTR_W:0]   tail_sum;
    logic [CMP_W-1:0] lim_ext, lim_eff;
    logic             hi_we, lo_we, hi_re, lo_re;
    logic [PTR_W-1:0] hi_raddr, lo_raddr;
    tpqs_pkg::entry_t wentry, hi_rdata, lo_rdata, rentry;
    tpqs_pkg::stat_evt_t evt;
    logic [tpqs_pkg::TIME_W-1:0] wait_calc;

    assign busy      = (state_reg == ST_READ);
    assign cfg_ready = 1'b1;
    assign accept    = start && !busy;
    assign is_tick   = op[tpqs_pkg::OP_TICK_BIT];
    assign cls       = op[tpqs_pkg::OP_CLASS_BIT];

    assign occ_sel  = cls ? lo_occ_reg : hi_occ_reg;
    assign head_sel = cls ? lo_head_reg : hi_head_reg;
    assign lim_ext  = CMP_W'(limit_reg);
    assign lim_eff  = (lim_ext < CMP_DEPTH) ? lim_ext : CMP_DEPTH;
    assign room     = CMP_W'(occ_sel) < lim_eff;
    assign tail_sum = {1'b0, head_sel} + (PTR_W + 1)'(occ_sel);
    assign tail     = (tail_sum >= SUM_DEPTH) ? PTR_W'(tail_sum - SUM_DEPTH)
                                              : PTR_W'(tail_sum);

    assign wentry.tag   = plane_tag;
    assign wentry.start = start_time;
    assign rentry       = srv_cls_reg ? lo_rdata : hi_rdata;
    assign wait_calc    = now_reg - rentry.start;

    always_comb
    begin
        state_next   = state_reg;
        hi_head_next = hi_head_reg;
        lo_head_next = lo_head_reg;
        hi_occ_next  = hi_occ_reg;
        lo_occ_next  = lo_occ_reg;
        srv_cls_next = srv_cls_reg;
        now_next     = now_reg;
        done_next    = 1'b0;
        status_next  = status_reg;
        tag_next     = tag_reg;
        wait_next    = wait_reg;
        hi_we        = 1'b0;
        lo_we        = 1'b0;
        hi_re        = 1'b0;
        lo_re        = 1'b0;
        hi_raddr     = hi_head_reg;
        lo_raddr     = lo_head_reg;
        evt          = '0;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (!is_tick)
                    begin
                        done_next   = 1'b1;
                        tag_next    = '0;
                        wait_next   = '0;
                        evt.req_high = !cls;
                        evt.req_low  = cls;
                        if (room)
                        begin
                            status_next = tpqs_pkg::STATUS_ACCEPTED;
                            if (cls)
                            begin
                                lo_we       = 1'b1;
                                lo_occ_next = lo_occ_reg + 1'b1;
                            end
                            else
                            begin
                                hi_we       = 1'b1;
                                hi_occ_next = hi_occ_reg + 1'b1;
                            end
                        end
                        else
                        begin
                            status_next  = tpqs_pkg::STATUS_REFUSED;
                            evt.ref_high = !cls;
                            evt.ref_low  = cls;
                        end
                    end
                    else if (hi_occ_reg != '0)
                    begin
                        hi_re        = 1'b1;
                        srv_cls_next = 1'b0;
                        now_next     = current_time;
                        state_next   = ST_READ;
                    end
                    else if (lo_occ_reg != '0)
                    begin
                        lo_re        = 1'b1;
                        srv_cls_next = 1'b1;
                        now_next     = current_time;
                        state_next   = ST_READ;
                    end
                    else
                    begin
                        done_next   = 1'b1;
                        status_next = tpqs_pkg::STATUS_IDLE;
                        tag_next    = '0;
                        wait_next   = '0;
                        evt.idle    = 1'b1;
                    end
                end
            end
            ST_READ:
            begin
                done_next  = 1'b1;
                tag_next   = rentry.tag;
                wait_next  = wait_calc;
                state_next = ST_IDLE;
                if (srv_cls_reg)
                begin
                    status_next  = tpqs_pkg::STATUS_LOW_SERVE;
                    evt.srv_low  = 1'b1;
                    lo_occ_next  = lo_occ_reg - 1'b1;
                    lo_head_next = (lo_head_reg == PTR_LAST) ? '0 : lo_head_reg + 1'b1;
                end
                else
                begin
                    status_next  = tpqs_pkg::STATUS_HIGH_SERVE;
                    evt.srv_high = 1'b1;
                    hi_occ_next  = hi_occ_reg - 1'b1;
                    hi_head_next = (hi_head_reg == PTR_LAST) ? '0 : hi_head_reg + 1'b1;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            limit_reg   <= tpqs_pkg::LIMIT_RESET;
            hi_head_reg <= '0;
            lo_head_reg <= '0;
            hi_occ_reg  <= '0;
            lo_occ_reg  <= '0;
            srv_cls_reg <= 1'b0;
            done_reg    <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            hi_head_reg <= hi_head_next;
            lo_head_reg <= lo_head_next;
            hi_occ_reg  <= hi_occ_next;
            lo_occ_reg  <= lo_occ_next;
            srv_cls_reg <= srv_cls_next;
            done_reg    <= done_next;
            if (cfg_valid && cfg_ready)
            begin
                limit_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        now_reg    <= now_next;
        status_reg <= status_next;
        tag_reg    <= tag_next;
        wait_reg   <= wait_next;
    end

    tpqs_queue_mem #(
        .DEPTH (QUEUE_DEPTH),
        .PTR_W (PTR_W)
    ) u_high_mem (
        .clk   (clk),
        .we    (hi_we),
        .waddr (tail),
        .wdata (wentry),
        .re    (hi_re),
        .raddr (hi_raddr),
        .rdata (hi_rdata)
    );

    tpqs_queue_mem #(
        .DEPTH (QUEUE_DEPTH),
        .PTR_W (PTR_W)
    ) u_low_mem (
        .clk   (clk),
        .we    (lo_we),
        .waddr (tail),
        .wdata (wentry),
        .re    (lo_re),
        .raddr (lo_raddr),
        .rdata (lo_rdata)
    );

    tpqs_stats u_stats (
        .clk             (clk),
        .rst_n           (rst_n),
        .evt             (evt),
        .wait_val        (wait_calc),
        .high_requests   (high_requests),
        .high_refused    (high_refused),
        .low_requests    (low_requests),
        .low_refused     (low_refused),
        .high_served     (high_served),
        .low_served      (low_served),
        .high_wait_total (high_wait_total),
        .low_wait_total  (low_wait_total),
        .idle_ticks      (idle_ticks)
    );

    assign done        = done_reg;
    assign status      = status_reg;
    assign served_tag  = tag_reg;
    assign served_wait = wait_reg;

endmodule

`default_nettype wire
